/* rtl/bed_pkg.sv */
// Shared constants for the button event detector: codes, register map and reset values.
`timescale 1ns / 1ps
package bed_pkg;

  localparam int unsigned TICK_W   = 32;
  localparam int unsigned WIN_W    = 16;
  localparam int unsigned EVENT_W  = 2;
  localparam int unsigned PHASE_W  = 2;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned APB_AW   = 4;
  localparam int unsigned REG_IDXW = 2;

  localparam logic [EVENT_W-1:0] EV_DOWN   = 2'd0;
  localparam logic [EVENT_W-1:0] EV_UP     = 2'd1;
  localparam logic [EVENT_W-1:0] EV_DOUBLE = 2'd2;
  localparam logic [EVENT_W-1:0] EV_HELD   = 2'd3;

  localparam logic [PHASE_W-1:0] PH_IDLE    = 2'd0;
  localparam logic [PHASE_W-1:0] PH_PRESS   = 2'd1;
  localparam logic [PHASE_W-1:0] PH_WAIT    = 2'd2;
  localparam logic [PHASE_W-1:0] PH_RELEASE = 2'd3;

  localparam logic [REG_IDXW-1:0] REG_INVERT = 2'd0;
  localparam logic [REG_IDXW-1:0] REG_WINDOW = 2'd1;
  localparam logic [REG_IDXW-1:0] REG_HOLD   = 2'd2;

  localparam logic [WIN_W-1:0] WINDOW_RST = 16'd500;
  localparam logic [WIN_W-1:0] HOLD_RST   = 16'd4000;

  typedef logic [TICK_W-1:0]  tick_t;
  typedef logic [WIN_W-1:0]   win_t;
  typedef logic [EVENT_W-1:0] event_t;
  typedef logic [PHASE_W-1:0] phase_t;

endpackage

/* rtl/bed_if.sv */
// Valid/ready channel interfaces for polls in and events out.
`timescale 1ns / 1ps
interface bed_poll_if;
  import bed_pkg::*;

  logic  valid;
  logic  ready;
  tick_t now_ticks;
  logic  pin_level;

  modport source (output valid, output now_ticks, output pin_level, input ready);
  modport sink   (input valid, input now_ticks, input pin_level, output ready);
endinterface

interface bed_event_if;
  import bed_pkg::*;

  logic   valid;
  logic   ready;
  event_t event_code;

  modport source (output valid, output event_code, input ready);
  modport sink   (input valid, input event_code, output ready);
endinterface

/* rtl/button_event_detector_unit.sv */
// Top level: push-button detector with down, up, double click and hold events.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+---------------------------
//   poll     | in  | valid/ready        | now_ticks[31:0], pin_level
//   evt      | out | valid/ready        | event_code[1:0]
//   apb      | in  | psel/penable/pready| paddr[3:0], pwdata, prdata
//
// One poll is accepted per cycle unless an event is stalled; its event, if any,
// appears in the output register on the next cycle, set by a 32-bit subtract and compare.
// Reset clears phase, press start, invert and out valid; presets window and hold.
// A stalled event holds the output register; a poll is still taken in the
// cycle the waiting event is taken, otherwise input ready drops.
`timescale 1ns / 1ps
module button_event_detector_unit (
  input  logic                      clk,
  input  logic                      rst,
  bed_poll_if.sink                  poll,
  bed_event_if.source               evt,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [bed_pkg::APB_AW-1:0] paddr,
  input  logic [bed_pkg::APB_DW-1:0] pwdata,
  output logic [bed_pkg::APB_DW-1:0] prdata,
  output logic                      pready
);
  import bed_pkg::*;

  logic   invert_level;
  win_t   double_click_window;
  win_t   hold_interval;

  phase_t phase;
  phase_t phase_next;
  tick_t  press_start;
  tick_t  press_start_next;

  logic   out_valid;
  event_t out_code;

  logic   poll_acc;
  logic   pressed;
  tick_t  elapsed;
  logic   emit;
  event_t code_next;
  logic   cfg_wr;
  logic [REG_IDXW-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      invert_level        <= 1'b0;
      double_click_window <= WINDOW_RST;
      hold_interval       <= HOLD_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_INVERT: invert_level        <= pwdata[0];
        REG_WINDOW: double_click_window <= pwdata[WIN_W-1:0];
        REG_HOLD:   hold_interval       <= pwdata[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_INVERT: prdata = {{(APB_DW-1){1'b0}}, invert_level};
      REG_WINDOW: prdata = {{(APB_DW-WIN_W){1'b0}}, double_click_window};
      REG_HOLD:   prdata = {{(APB_DW-WIN_W){1'b0}}, hold_interval};
      default:    prdata = '0;
    endcase
  end

  assign poll.ready = !out_valid || evt.ready;
  assign poll_acc   = poll.valid && poll.ready;
  assign pressed    = poll.pin_level ^ invert_level;
  assign elapsed    = poll.now_ticks - press_start;

  always_comb begin
    phase_next       = phase;
    press_start_next = press_start;
    emit             = 1'b0;
    code_next        = EV_DOWN;
    unique case (phase)
      PH_IDLE: begin
        if (pressed) begin
          if (elapsed < {{(TICK_W-WIN_W){1'b0}}, double_click_window}) begin
            emit             = 1'b1;
            code_next        = EV_DOUBLE;
            press_start_next = poll.now_ticks;
          end
          phase_next = PH_PRESS;
        end
      end
      PH_PRESS: begin
        emit             = 1'b1;
        code_next        = EV_DOWN;
        press_start_next = poll.now_ticks;
        phase_next       = PH_WAIT;
      end
      PH_WAIT: begin
        if (!pressed) begin
          phase_next = PH_RELEASE;
        end
        if (elapsed > {{(TICK_W-WIN_W){1'b0}}, hold_interval}) begin
          emit             = 1'b1;
          code_next        = EV_HELD;
          press_start_next = poll.now_ticks;
        end
      end
      default: begin
        emit       = 1'b1;
        code_next  = EV_UP;
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      press_start <= '0;
    end else if (poll_acc) begin
      phase       <= phase_next;
      press_start <= press_start_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (poll_acc) begin
      out_valid <= emit;
    end else if (evt.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (poll_acc && emit) begin
      out_code <= code_next;
    end
  end

  assign evt.valid      = out_valid;
  assign evt.event_code = out_code;

endmodule

/* rtl/bed_checker.sv */
// Port-level checker for the button event detector, bound to the top level.
`timescale 1ns / 1ps
module bed_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [bed_pkg::EVENT_W-1:0] out_code
);
  import bed_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_code))
    else $error("stalled item changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input not ready with empty output");

  a_block_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_item_from_poll: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("output item without accepted poll");

endmodule

bind button_event_detector_unit bed_checker u_bed_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (poll.valid),
  .in_ready  (poll.ready),
  .out_valid (evt.valid),
  .out_ready (evt.ready),
  .out_code  (evt.event_code)
);
